[hdl/mrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the modem response classifier: item kinds,
// the fixed reply strings and the control bundle of a window cell.
// ----------------------------------------------------------------------------
package mrc_pkg;

    // number of fixed replies and bytes of history kept before the newest byte
    localparam int NUM_REPLIES = 12;
    localparam int WINDOW      = 9;
    localparam int CODE_W      = 4;
    localparam int TICK_W      = 17;
    localparam int LIMIT_W     = 16;

    // item kinds
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    // characters with special handling
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // reply strings, right aligned: last character in bits [7:0]
    localparam logic [79:0] REPLY_TEXT [NUM_REPLIES] = '{
        80'("OK"),
        80'("ERROR"),
        80'("CONNECT"),
        80'("NO CARRIER"),
        80'("IP STATUS"),
        80'("IP INITIAL"),
        80'("SHUT OK"),
        80'("CLOSED"),
        80'("DEACT"),
        80'("READY"),
        80'("."),
        80'("POWER DOWN")
    };

    localparam logic [3:0] REPLY_LEN [NUM_REPLIES] = '{
        4'd2, 4'd5, 4'd7, 4'd10, 4'd9, 4'd10, 4'd7, 4'd6, 4'd5, 4'd5, 4'd1, 4'd10
    };

    // control of one window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

[hdl/mrc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_cell
// One position of the byte history. Holds a byte, takes its neighbor's byte
// on a store and checks its byte against every reply at its distance from
// the end of the reply.
// ----------------------------------------------------------------------------
module mrc_cell #(
    parameter int POS = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mrc_pkg::cell_ctrl_t                 ctrl,
    input  logic [7:0]                          byte_in,
    output logic [7:0]                          byte_out,
    output logic [mrc_pkg::NUM_REPLIES-1:0]     match
);
    import mrc_pkg::*;

    // distance of this cell's byte from the end of a reply
    localparam int DIST = POS + 1;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // shift or clear the held byte
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = CHAR_NUL;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= CHAR_NUL;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // per reply compare; positions beyond a reply's length always agree
    always_comb
    begin
        for (int k = 0; k < NUM_REPLIES; k++)
        begin
            if (DIST >= int'(REPLY_LEN[k]))
            begin
                match[k] = 1'b1;
            end
            else
            begin
                match[k] = (byte_reg == REPLY_TEXT[k][8*DIST +: 8]);
            end
        end
    end

    assign byte_out = byte_reg;

endmodule

[hdl/modem_response_classifier_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_classifier_core
// Classifies modem reply text over one timed session and returns the code of
// the highest-ranked reply seen.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while in_ready is high. Received bytes
// move through a row of nine cells that hold the recent text; each cell
// compares its byte with all twelve replies in parallel, so a byte's match
// flags are settled in the cycle it is accepted. The response code goes into
// an output register and is offered the cycle after the timing-out tick is
// accepted. While that code waits, items that cause no result are still
// taken; a tick that would time out waits until the output register is free.
// ----------------------------------------------------------------------------
module modem_response_classifier_core #(
    parameter int TEXT_DEPTH = 60
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic [7:0]                      rx_byte,
    input  logic [mrc_pkg::LIMIT_W-1:0]     limit_ticks,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mrc_pkg::CODE_W-1:0]      response_code
);
    import mrc_pkg::*;

    localparam int COUNT_W = $clog2(TEXT_DEPTH + 1);

    logic [NUM_REPLIES-1:0] found_reg, found_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   ended_reg, ended_next;
    logic                   open_reg, open_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]      code_reg, code_next;

    logic                   accept;
    logic                   is_start;
    logic                   is_byte;
    logic                   is_tick;
    logic [TICK_W-1:0]      tick_inc;
    logic                   tick_fires;
    logic                   store;
    logic [7:0]             byte_map;
    logic [NUM_REPLIES-1:0] hit;
    logic [CODE_W-1:0]      best_code;
    cell_ctrl_t             cell_ctrl;
    logic [7:0]             cell_byte [WINDOW-1];
    logic [NUM_REPLIES-1:0] cell_match [WINDOW];

    // item decode
    always_comb
    begin
        is_start = 1'b0;
        is_byte  = 1'b0;
        is_tick  = 1'b0;
        unique case (kind_t'(kind))
            KIND_START: is_start = 1'b1;
            KIND_BYTE:  is_byte  = 1'b1;
            KIND_TICK:  is_tick  = 1'b1;
            default:    ;
        endcase
    end

    // timeout check and handshake
    assign tick_inc   = tick_reg + TICK_W'(1);
    assign tick_fires = is_tick && open_reg && (tick_inc > TICK_W'(limit_reg));
    assign in_ready   = !out_valid_reg || out_ready || !tick_fires;
    assign accept     = in_valid && in_ready;
    assign store      = accept && is_byte && open_reg &&
                        (count_reg < COUNT_W'(TEXT_DEPTH));

    // line ends are kept as spaces
    assign byte_map = ((rx_byte == CHAR_CR) || (rx_byte == CHAR_LF)) ? CHAR_SPACE : rx_byte;

    // cell row control
    assign cell_ctrl.shift = store;
    assign cell_ctrl.clear = accept && tick_fires;

    // row of history cells, newest first
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            logic [7:0] chain_in;
            if (gi == 0)
            begin : g_head
                assign chain_in = byte_map;
            end
            else
            begin : g_body
                assign chain_in = cell_byte[gi-1];
            end

            if (gi < WINDOW - 1)
            begin : g_mid
                mrc_cell #(
                    .POS (gi)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .byte_in  (chain_in),
                    .byte_out (cell_byte[gi]),
                    .match    (cell_match[gi])
                );
            end
            else
            begin : g_tail
                mrc_cell #(
                    .POS (gi)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cell_ctrl),
                    .byte_in  (chain_in),
                    .byte_out (),
                    .match    (cell_match[gi])
                );
            end
        end
    endgenerate

    // a reply ends at the new byte when its last character matches and all
    // cells agree
    always_comb
    begin
        for (int k = 0; k < NUM_REPLIES; k++)
        begin
            hit[k] = (byte_map == REPLY_TEXT[k][7:0]);
            for (int i = 0; i < WINDOW; i++)
            begin
                hit[k] = hit[k] && cell_match[i][k];
            end
        end
    end

    // highest found reply wins
    always_comb
    begin
        best_code = '0;
        for (int k = 0; k < NUM_REPLIES; k++)
        begin
            if (found_reg[k])
            begin
                best_code = CODE_W'(k + 1);
            end
        end
    end

    // session state update
    always_comb
    begin
        found_next     = found_reg;
        count_next     = count_reg;
        ended_next     = ended_reg;
        open_next      = open_reg;
        tick_next      = tick_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_next      = code_reg;

        if (accept)
        begin
            if (is_start)
            begin
                open_next  = 1'b1;
                limit_next = limit_ticks;
                tick_next  = '0;
            end
            else if (store)
            begin
                count_next = count_reg + COUNT_W'(1);
                if (byte_map == CHAR_NUL)
                begin
                    ended_next = 1'b1;
                end
                else if (!ended_reg)
                begin
                    found_next = found_reg | hit;
                end
            end
            else if (is_tick && open_reg)
            begin
                if (tick_fires)
                begin
                    out_valid_next = 1'b1;
                    code_next      = best_code;
                    found_next     = '0;
                    count_next     = '0;
                    ended_next     = 1'b0;
                    open_next      = 1'b0;
                    tick_next      = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= '0;
            count_reg     <= '0;
            ended_reg     <= 1'b0;
            open_reg      <= 1'b0;
            tick_reg      <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            count_reg     <= count_next;
            ended_reg     <= ended_next;
            open_reg      <= open_next;
            tick_reg      <= tick_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign out_valid     = out_valid_reg;
    assign response_code = code_reg;

endmodule

[dv/modem_response_classifier_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_classifier_checker
// Watches both channels of the modem response classifier, keeps its own copy
// of the session, tick and reply-text state, predicts the response code of
// every timed-out session and compares each code the block returns with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module modem_response_classifier_checker #(
    parameter int TEXT_DEPTH = 60
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic [7:0]                      rx_byte,
    input  logic [mrc_pkg::LIMIT_W-1:0]     limit_ticks,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [mrc_pkg::CODE_W-1:0]      response_code,
    output int                              fail_count,
    output int                              codes_outstanding,
    output int                              codes_seen
);

    import mrc_pkg::*;

    // text and session state of the block as the items see it
    logic [7:0]             text_window [WINDOW];
    logic [NUM_REPLIES-1:0] found_replies;
    int                     bytes_stored;
    bit                     text_closed;
    bit                     session_live;
    logic [TICK_W-1:0]      ticks_elapsed;
    logic [LIMIT_W-1:0]     tick_limit;

    // codes owed by sessions that timed out, oldest first
    logic [CODE_W-1:0]      expected_codes [$];
    logic [CODE_W-1:0]      want_code;

    // does reply k end with byte b, given the bytes stored before it
    function automatic bit reply_ends_with(input int k, input logic [7:0] b);
        int len;
        bit hit;
        len = int'(REPLY_LEN[k]);
        hit = (REPLY_TEXT[k][7:0] == b);
        for (int i = 0; i < len - 1 && i < WINDOW; i++)
        begin
            if (REPLY_TEXT[k][8*(i+1) +: 8] != text_window[i])
                hit = 1'b0;
        end
        return hit;
    endfunction

    // highest reply index found, zero when none
    function automatic logic [CODE_W-1:0] best_reply_code();
        for (int k = NUM_REPLIES - 1; k >= 0; k--)
        begin
            if (found_replies[k])
                return CODE_W'(k + 1);
        end
        return '0;
    endfunction

    task automatic clear_text();
        for (int i = 0; i < WINDOW; i++)
            text_window[i] = CHAR_NUL;
        found_replies = '0;
        bytes_stored  = 0;
        text_closed   = 1'b0;
    endtask

    // store one received byte, matching replies unless the text has ended
    task automatic store_rx_byte(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (bytes_stored >= TEXT_DEPTH)
            return;
        if (c == CHAR_LF || c == CHAR_CR)
            c = CHAR_SPACE;
        bytes_stored++;
        if (c == CHAR_NUL)
            text_closed = 1'b1;
        if (!text_closed)
        begin
            for (int k = 0; k < NUM_REPLIES; k++)
            begin
                if (reply_ends_with(k, c))
                    found_replies[k] = 1'b1;
            end
        end
        for (int i = WINDOW - 1; i > 0; i--)
            text_window[i] = text_window[i-1];
        text_window[0] = c;
    endtask

    // advance the state by one accepted item
    task automatic apply_item(input logic [1:0] k, input logic [7:0] b,
                              input logic [LIMIT_W-1:0] lim);
        case (k)
            KIND_START:
            begin
                session_live  = 1'b1;
                tick_limit    = lim;
                ticks_elapsed = '0;
            end
            KIND_BYTE:
            begin
                if (session_live)
                    store_rx_byte(b);
            end
            KIND_TICK:
            begin
                if (session_live)
                begin
                    ticks_elapsed = ticks_elapsed + 1'b1;
                    if (ticks_elapsed > {1'b0, tick_limit})
                    begin
                        expected_codes.push_back(best_reply_code());
                        clear_text();
                        session_live  = 1'b0;
                        ticks_elapsed = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_text();
            session_live  = 1'b0;
            ticks_elapsed = '0;
            tick_limit    = '0;
            expected_codes.delete();
            fail_count        = 0;
            codes_outstanding = 0;
            codes_seen        = 0;
        end
        else
        begin
            // a code on the output always belongs to an earlier tick
            if (out_valid && out_ready)
            begin
                codes_seen++;
                if (expected_codes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: response_code expected none, actual %0d",
                             $time, response_code);
                end
                else
                begin
                    want_code = expected_codes.pop_front();
                    if (response_code !== want_code)
                    begin
                        fail_count++;
                        $display("%0t ns: response_code expected %0d, actual %0d",
                                 $time, want_code, response_code);
                    end
                end
            end
            if (in_valid && in_ready)
                apply_item(kind, rx_byte, limit_ticks);
            codes_outstanding = expected_codes.size();
        end
    end

endmodule

[dv/modem_response_classifier_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_classifier_core_tb
// Drives sessions of modem reply text into the classifier: directed corner
// cases, a long output stall that backs up the input, then random sessions of
// reply strings, noise bytes, restarts and ticks, with random idling on both
// channels. A separate checker predicts and compares every response code.
// ----------------------------------------------------------------------------
module modem_response_classifier_core_tb;

    import mrc_pkg::*;

    localparam int         TEXT_DEPTH     = 60;
    localparam int         RANDOM_ITEMS   = 750;
    localparam int         MIN_SESSIONS   = 20;
    // receiver hold that backs the block up
    localparam int         RX_HOLD_CYCLES = 300;
    // well above the longest legal quiet stretch (hold plus longest gap)
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             kind;
    logic [7:0]             rx_byte;
    logic [LIMIT_W-1:0]     limit_ticks;
    logic                   out_valid;
    logic                   out_ready;
    logic [CODE_W-1:0]      response_code;

    int fail_count;
    int codes_outstanding;
    int codes_seen;

    int items_sent;
    int sessions_done;
    int sender_burst;
    int holds_asked;
    int holds_served;
    int quiet_cycles;

    modem_response_classifier_core #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .limit_ticks   (limit_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .response_code (response_code)
    );

    modem_response_classifier_checker #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) code_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .rx_byte           (rx_byte),
        .limit_ticks       (limit_ticks),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .response_code     (response_code),
        .fail_count        (fail_count),
        .codes_outstanding (codes_outstanding),
        .codes_seen        (codes_seen)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle cycles before the next item: mostly none, a few long
    function automatic int next_gap();
        int r;
        if (sender_burst > 0)
        begin
            sender_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            sender_burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(input logic [1:0] k, input logic [7:0] b,
                             input logic [LIMIT_W-1:0] lim);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        rx_byte     <= b;
        limit_ticks <= lim;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic open_session(input logic [LIMIT_W-1:0] lim);
        send_item(KIND_START, 8'($urandom), lim);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(KIND_BYTE, b, LIMIT_W'($urandom));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(KIND_TICK, 8'($urandom), LIMIT_W'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_rx(s[i]);
    endtask

    // lowercase letters never form part of a reply
    task automatic send_filler(input int n);
        repeat (n) send_rx(8'($urandom_range(8'h61, 8'h7A)));
    endtask

    // one reply string, optionally with one character replaced
    task automatic send_reply(input int k, input bit spoil);
        int len;
        int bad;
        logic [7:0] c;
        len = int'(REPLY_LEN[k]);
        bad = spoil ? $urandom_range(0, len - 1) : -1;
        for (int j = 0; j < len; j++)
        begin
            c = REPLY_TEXT[k][8*(len-1-j) +: 8];
            if (j == bad)
                c = 8'($urandom);
            send_rx(c);
        end
    endtask

    // stray items while no session is open; the block drops them
    task automatic send_noise();
        logic [1:0] k;
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 2))
                0:       k = KIND_BYTE;
                1:       k = KIND_TICK;
                default: k = KIND_UNUSED;
            endcase
            send_item(k, 8'($urandom), LIMIT_W'($urandom));
            items_sent--;
        end
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LIMIT_W'($urandom_range(0, 3));
        if (r < 95)
            return LIMIT_W'($urandom_range(4, 12));
        return LIMIT_W'($urandom_range(13, 100));
    endfunction

    // one session: start, mixed text and early ticks, then ticks to timeout
    task automatic random_session();
        logic [LIMIT_W-1:0] lim;
        int ticks_used;
        int pick;
        lim = pick_limit();
        open_session(lim);
        ticks_used = 0;
        // now and then fill most or all of the store so later text may be dropped
        if ($urandom_range(0, 11) == 0)
            send_filler($urandom_range(50, 70));
        repeat ($urandom_range(0, 5))
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                send_reply($urandom_range(0, NUM_REPLIES - 1), $urandom_range(0, 4) == 0);
            else if (pick < 13)
                repeat ($urandom_range(1, 6)) send_rx(8'($urandom));
            else if (pick < 15)
            begin
                case ($urandom_range(0, 2))
                    0:       send_rx(CHAR_CR);
                    1:       send_rx(CHAR_LF);
                    default: send_rx(CHAR_SPACE);
                endcase
            end
            else if (pick < 16)
                send_rx(CHAR_NUL);
            else if (pick < 19)
            begin
                if (ticks_used < int'(lim))
                begin
                    send_ticks(1);
                    ticks_used++;
                end
            end
            else
            begin
                // restart keeps the text; a far timeout is replaced at once
                if ($urandom_range(0, 1) == 1)
                    open_session(LIMIT_W'($urandom));
                lim = pick_limit();
                open_session(lim);
                ticks_used = 0;
            end
        end
        send_ticks(int'(lim) + 1 - ticks_used);
        sessions_done++;
        if ($urandom_range(0, 4) == 0)
            send_noise();
    endtask

    // receiver: random stalls, ready stretches, and the long hold on request
    initial
    begin : receiver
        int stall_left;
        int ready_left;
        int r;
        out_ready    = 1'b0;
        holds_served = 0;
        stall_left   = 0;
        ready_left   = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                holds_served++;
                stall_left = 0;
                ready_left = 0;
            end
            else if (ready_left > 0)
            begin
                out_ready <= 1'b1;
                ready_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 5)
                    ready_left = $urandom_range(30, 80);
                else if (r < 55)
                    ready_left = $urandom_range(0, 4);
                else if (r < 90)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(10, 40);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("modem_response_classifier_core verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_START;
        rx_byte       = 8'h00;
        limit_ticks   = '0;
        items_sent    = 0;
        sessions_done = 0;
        sender_burst  = 0;
        holds_asked   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // no session open: bytes, ticks and the unused kind are dropped
        send_item(KIND_TICK, 8'h00, 16'h0000);
        send_text("OK");
        send_item(KIND_UNUSED, 8'hFF, 16'hFFFF);
        send_ticks(1);

        // zero timeout: the first tick ends the session
        open_session(16'd0);
        send_text("OK");
        send_ticks(1);

        // restart keeps the text and takes the new timeout
        open_session(16'hFFFF);
        send_text("POWER");
        send_item(KIND_UNUSED, 8'h5A, 16'h0000);
        send_text(" DOWN");
        open_session(16'd2);
        send_text("ERROR");
        send_ticks(3);

        // CR and LF are stored as spaces
        open_session(16'd1);
        send_text("SHUT");
        send_rx(CHAR_LF);
        send_text("OK NO");
        send_rx(CHAR_CR);
        send_text("CARRIER");
        send_ticks(2);

        // a zero byte ends the text
        open_session(16'd3);
        send_rx(8'hFF);
        send_text("DEACT");
        send_rx(CHAR_NUL);
        send_text("READY.");
        send_ticks(4);

        // store full: a reply ending on the last stored byte counts
        open_session(16'd0);
        send_filler(TEXT_DEPTH - 2);
        send_text("OK.");
        send_ticks(1);

        // store full one byte earlier: the reply is cut off
        open_session(16'd0);
        send_filler(TEXT_DEPTH - 1);
        send_text("OK.");
        send_ticks(1);

        // long timeout: many ticks pass before the result
        open_session(16'd150);
        send_text("CONNECT");
        send_ticks(151);

        // long receiver hold while quick sessions keep coming
        holds_asked++;
        repeat (4)
        begin
            open_session(16'd0);
            send_reply($urandom_range(0, NUM_REPLIES - 1), 1'b0);
            send_ticks(1);
        end

        while (items_sent < RANDOM_ITEMS || sessions_done < MIN_SESSIONS)
            random_session();

        @(negedge clk);
        in_valid <= 1'b0;
        while (codes_outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0 && codes_outstanding == 0)
            $display("modem_response_classifier_core verification clean");
        else
            $display("modem_response_classifier_core verification failed");
        $finish;
    end

endmodule
